// ===== src/abr_pkg.sv =====
package abr_pkg;

  // Defaults for the top-level parameters
  localparam int GRID_COLUMNS_DEF = 5;
  localparam int ID_WIDTH_DEF     = 32;

  // Field widths
  localparam int MODE_W = 2;
  localparam int MSG_W  = 32;
  localparam int NODE_W = 5;
  localparam int RC_W   = 3;
  localparam int CNT_W  = 16;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 1;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_DATA = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;

  // Result ports
  localparam logic PORT_LINK = 1'b0;
  localparam logic PORT_TX   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_INDEX   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECEIVED = 1'd1;

  localparam logic [NODE_W-1:0] NODE_INDEX_RESET   = 5'd0;
  localparam logic [CNT_W-1:0]  MAX_RECEIVED_RESET = 16'd6900;

  // One input transaction
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              seq_bit;
    logic [MSG_W-1:0]  msg_id;
    logic [NODE_W-1:0] src_node;
  } abr_item_t;

  // One result transaction
  typedef struct packed {
    logic              port;
    logic              seq;
    logic [MSG_W-1:0]  id;
    logic [NODE_W-1:0] ack_src;
    logic [NODE_W-1:0] dest_node;
    logic [RC_W-1:0]   dest_row;
    logic [RC_W-1:0]   dest_col;
    logic              is_finished;
  } abr_result_t;

  // Configuration register contents
  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [CNT_W-1:0]  max_received;
  } abr_cfg_t;

endpackage

// ===== src/abr_in_stage.sv =====
module abr_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  abr_pkg::abr_item_t in_item,
  input  logic               advance,
  output logic               item_valid,
  output abr_pkg::abr_item_t item
);

  logic               valid_r;
  logic               valid_nxt;
  abr_pkg::abr_item_t item_r;
  logic               load;

  // Hold the registered item while the core cannot take it
  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== src/abr_rx_core.sv =====
module abr_rx_core #(
  parameter int GRID_COLUMNS = abr_pkg::GRID_COLUMNS_DEF,
  parameter int ID_WIDTH     = abr_pkg::ID_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  abr_pkg::abr_cfg_t    cfg,
  input  logic                 item_valid,
  input  abr_pkg::abr_item_t   item,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output abr_pkg::abr_result_t result
);

  localparam int NODES = 2 ** abr_pkg::NODE_W;

  logic                     expected_bit_r, expected_bit_nxt;
  logic [ID_WIDTH-1:0]      last_id0_r, last_id0_nxt;
  logic [ID_WIDTH-1:0]      last_id1_r, last_id1_nxt;
  logic [abr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                     finished_r, finished_nxt;
  logic                     out_valid_r, out_valid_nxt;
  abr_pkg::abr_result_t     result_r, result_nxt;

  logic                  take;
  logic                  is_data;
  logic                  is_ack;
  logic                  emit;
  logic                  is_new;
  logic [ID_WIDTH-1:0]   sid;
  logic [ID_WIDTH-1:0]   last_sel;
  logic [abr_pkg::RC_W-1:0] row_tab [NODES];
  logic [abr_pkg::RC_W-1:0] col_tab [NODES];

  // Build row and column lookup for every node number
  for (genvar i = 0; i < NODES; i++) begin : g_grid
    localparam int ROW = (i / GRID_COLUMNS) % 8;
    localparam int COL = (i % GRID_COLUMNS) % 8;
    assign row_tab[i] = abr_pkg::RC_W'(ROW);
    assign col_tab[i] = abr_pkg::RC_W'(COL);
  end

  // Advance when the result register is free or being drained
  assign advance = !out_valid_r || !out_stall;
  assign take    = item_valid && advance;

  assign is_data  = (item.mode == abr_pkg::MODE_DATA);
  assign is_ack   = (item.mode == abr_pkg::MODE_ACK);
  assign emit     = is_ack || (is_data && !finished_r);
  assign sid      = ID_WIDTH'(item.msg_id);
  assign last_sel = item.seq_bit ? last_id1_r : last_id0_r;
  assign is_new   = is_data && !finished_r && (item.seq_bit == expected_bit_r) &&
                    (sid > last_sel);

  // Update receiver state for a new message
  always_comb begin
    expected_bit_nxt = expected_bit_r;
    last_id0_nxt     = last_id0_r;
    last_id1_nxt     = last_id1_r;
    count_nxt        = count_r;
    finished_nxt     = finished_r;
    if (take && is_new) begin
      if (item.seq_bit) begin
        last_id1_nxt = sid;
      end else begin
        last_id0_nxt = sid;
      end
      if (count_r >= cfg.max_received) begin
        finished_nxt = 1'b1;
      end else begin
        count_nxt        = count_r + abr_pkg::CNT_W'(1);
        expected_bit_nxt = ~expected_bit_r;
      end
    end
  end

  // Form the result: link ack or transmitter notice
  always_comb begin
    result_nxt             = '0;
    result_nxt.seq         = item.seq_bit;
    result_nxt.id          = item.msg_id;
    result_nxt.is_finished = finished_nxt;
    if (is_ack) begin
      result_nxt.port = abr_pkg::PORT_TX;
    end else begin
      result_nxt.port      = abr_pkg::PORT_LINK;
      result_nxt.ack_src   = cfg.node_index;
      result_nxt.dest_node = item.src_node;
      result_nxt.dest_row  = row_tab[item.src_node];
      result_nxt.dest_col  = col_tab[item.src_node];
    end
  end

  assign out_valid_nxt = advance ? (take && emit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_bit_r <= 1'b0;
      last_id0_r     <= '0;
      last_id1_r     <= '0;
      count_r        <= '0;
      finished_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      expected_bit_r <= expected_bit_nxt;
      last_id0_r     <= last_id0_nxt;
      last_id1_r     <= last_id1_nxt;
      count_r        <= count_nxt;
      finished_r     <= finished_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Load the result register with each emitted transaction
  always_ff @(posedge clk) begin
    if (take && emit) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

// ===== src/alternating_bit_receiver.sv =====
// Alternating-bit stop-and-wait receiver. Each accepted transaction passes
// through an input register and then combinational decision logic into a
// result register, so one transaction is taken per clock while the result
// register is not stalled; a stalled result register holds the input side
// only once the input register is also full. Data transactions
// (mode 0) with the expected bit and a newer id advance the state and are
// acked toward the link; duplicates and wrong bits are re-acked. Peer
// acknowledgements (mode 1) are forwarded to the local transmitter in any
// state. Other modes and data after the finished state give no result.
// Write configuration only while the block is idle.
module alternating_bit_receiver #(
  parameter int GRID_COLUMNS = abr_pkg::GRID_COLUMNS_DEF,
  parameter int ID_WIDTH     = abr_pkg::ID_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [abr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abr_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [abr_pkg::MODE_W-1:0]     in_mode,
  input  logic                           in_seq_bit,
  input  logic [abr_pkg::MSG_W-1:0]      in_msg_id,
  input  logic [abr_pkg::NODE_W-1:0]     in_src_node,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_port,
  output logic                           out_seq,
  output logic [abr_pkg::MSG_W-1:0]      out_id,
  output logic [abr_pkg::NODE_W-1:0]     out_ack_src,
  output logic [abr_pkg::NODE_W-1:0]     out_dest_node,
  output logic [abr_pkg::RC_W-1:0]       out_dest_row,
  output logic [abr_pkg::RC_W-1:0]       out_dest_col,
  output logic                           out_is_finished
);

  abr_pkg::abr_cfg_t    cfg_r;
  abr_pkg::abr_item_t   in_item;
  abr_pkg::abr_item_t   item;
  abr_pkg::abr_result_t result;
  logic                 item_valid;
  logic                 advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_index   <= abr_pkg::NODE_INDEX_RESET;
      cfg_r.max_received <= abr_pkg::MAX_RECEIVED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        abr_pkg::CFG_NODE_INDEX: begin
          cfg_r.node_index <= cfg_wdata[abr_pkg::NODE_W-1:0];
        end
        abr_pkg::CFG_MAX_RECEIVED: begin
          cfg_r.max_received <= cfg_wdata[abr_pkg::CNT_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  assign in_item.mode     = in_mode;
  assign in_item.seq_bit  = in_seq_bit;
  assign in_item.msg_id   = in_msg_id;
  assign in_item.src_node = in_src_node;

  abr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  abr_rx_core #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .ID_WIDTH     (ID_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign out_port        = result.port;
  assign out_seq         = result.seq;
  assign out_id          = result.id;
  assign out_ack_src     = result.ack_src;
  assign out_dest_node   = result.dest_node;
  assign out_dest_row    = result.dest_row;
  assign out_dest_col    = result.dest_col;
  assign out_is_finished = result.is_finished;

endmodule
